### sv/uaa_pkg.sv
// ----------------------------------------------------------------------------
// uaa_pkg
// Shared types and constants for the unsigned to ASCII radix converter.
// ----------------------------------------------------------------------------
package uaa_pkg;

  localparam int VALUE_BITS = 32;               // bits of the value that are converted
  localparam int IN_W       = 32;               // width of the value port
  localparam int BASE_W     = 6;
  localparam int DIGIT_W    = 6;                // one remainder, 0..35
  localparam int CHAR_W     = 7;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W     = $clog2(VALUE_BITS);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [BASE_W-1:0]  MIN_BASE  = BASE_W'(2);
  localparam logic [BASE_W-1:0]  MAX_BASE  = BASE_W'(36);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(48);   // '0'
  localparam logic [CHAR_W-1:0]  CHAR_A_10 = CHAR_W'(87);   // 'a' - 10
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_WR
  } st_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [BASE_W-1:0]     base;
    logic                  bad;
  } job_t;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DEC_DIGITS) return CHAR_ZERO + dx;
    else return CHAR_A_10 + dx;
  endfunction

endpackage

### sv/uaa_ram.sv
// ----------------------------------------------------------------------------
// uaa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module uaa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/uaa_front.sv
// ----------------------------------------------------------------------------
// uaa_front
// Input side: takes beats, flags bad bases, and holds them in a short queue.
// ----------------------------------------------------------------------------
module uaa_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [uaa_pkg::IN_W-1:0]    value,
  input  logic [uaa_pkg::BASE_W-1:0]  base,
  output uaa_pkg::job_t               job,
  output logic                        job_valid,
  input  logic                        job_pop
);

  import uaa_pkg::*;

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [QPTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [QCNT_W-1:0] count, count_next;
  logic              accept;
  job_t              new_job;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign accept    = push && !full;
  assign job_valid = (count != '0);
  assign job       = entries[rd_ptr];

  always_comb begin
    new_job.value = VALUE_BITS'(value);
    new_job.base  = base;
    new_job.bad   = (base < MIN_BASE) || (base > MAX_BASE);
  end

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (accept) begin
      wr_ptr_next = (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (job_pop) begin
      rd_ptr_next = (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (accept && !job_pop) begin
      count_next = count + 1'b1;
    end else if (!accept && job_pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= new_job;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count past depth");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> job_valid)
    else $error("accepted beat not visible to back end");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> job_valid)
    else $error("pop from empty queue");

endmodule

### sv/uaa_back.sv
// ----------------------------------------------------------------------------
// uaa_back
// Conversion engine: bit-serial divide per digit, digit RAM, and MSB-first
// readout into a single output register.
// ----------------------------------------------------------------------------
module uaa_back (
  input  logic                        clk,
  input  logic                        rst,
  input  uaa_pkg::job_t               job,
  input  logic                        job_valid,
  output logic                        job_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic [uaa_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last,
  output logic                        bad_base
);

  import uaa_pkg::*;

  localparam logic [ADDR_W-1:0] BIT_LAST = ADDR_W'(VALUE_BITS - 1);

  st_t                   state, state_next;
  logic [VALUE_BITS-1:0] quo, quo_next;
  logic [DIGIT_W-1:0]    rem, rem_next;
  logic [ADDR_W-1:0]     bitcnt, bitcnt_next;
  logic [CNT_W-1:0]      ndig, ndig_next;
  logic [ADDR_W-1:0]     idx, idx_next;
  logic [BASE_W-1:0]     base_r, base_next;
  logic                  out_valid, out_valid_next;
  logic [CHAR_W-1:0]     char_next;
  logic                  last_next, bad_next;

  logic                  out_free;
  logic [DIGIT_W:0]      rem_sh, rem_sub;
  logic                  ge;
  logic [DIGIT_W-1:0]    rem_n;
  logic [VALUE_BITS-1:0] quo_shift;
  logic                  ram_we;
  logic [DIGIT_W-1:0]    rdata;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  // one restoring-divide step per cycle, quotient bits shift in at the bottom
  assign rem_sh    = {rem, quo[VALUE_BITS-1]};
  assign rem_sub   = rem_sh - (DIGIT_W + 1)'(base_r);
  assign ge        = (rem_sh >= (DIGIT_W + 1)'(base_r));
  assign rem_n     = ge ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
  assign quo_shift = {quo[VALUE_BITS-2:0], ge};

  uaa_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ndig[ADDR_W-1:0]),
    .wdata (rem_n),
    .raddr (idx),
    .rdata (rdata)
  );

  always_comb begin
    state_next     = state;
    quo_next       = quo;
    rem_next       = rem;
    bitcnt_next    = bitcnt;
    ndig_next      = ndig;
    idx_next       = idx;
    base_next      = base_r;
    job_pop        = 1'b0;
    ram_we         = 1'b0;
    out_valid_next = out_valid && !pop;
    char_next      = digit_char;
    last_next      = last;
    bad_next       = bad_base;
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          if (job.bad) begin
            if (out_free) begin
              job_pop        = 1'b1;
              out_valid_next = 1'b1;
              char_next      = '0;
              last_next      = 1'b1;
              bad_next       = 1'b1;
            end
          end else begin
            job_pop     = 1'b1;
            quo_next    = job.value;
            rem_next    = '0;
            bitcnt_next = BIT_LAST;
            ndig_next   = '0;
            base_next   = job.base;
            state_next  = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        quo_next    = quo_shift;
        rem_next    = rem_n;
        bitcnt_next = bitcnt - 1'b1;
        if (bitcnt == '0) begin
          // digit done: store remainder, then continue on the quotient or start readout
          ram_we    = 1'b1;
          ndig_next = ndig + 1'b1;
          if (quo_shift == '0) begin
            idx_next   = ndig[ADDR_W-1:0];
            state_next = ST_RD;
          end else begin
            rem_next    = '0;
            bitcnt_next = BIT_LAST;
          end
        end
      end
      ST_RD: begin
        state_next = ST_WR;
      end
      ST_WR: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          char_next      = ascii_of(rdata);
          last_next      = (idx == '0);
          bad_next       = 1'b0;
          if (idx == '0) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx - 1'b1;
            state_next = ST_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      ndig      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      ndig      <= ndig_next;
    end
  end

  always_ff @(posedge clk) begin
    quo        <= quo_next;
    rem        <= rem_next;
    bitcnt     <= bitcnt_next;
    idx        <= idx_next;
    base_r     <= base_next;
    digit_char <= char_next;
    last       <= last_next;
    bad_base   <= bad_next;
  end

  a_ndig_range: assert property (@(posedge clk) disable iff (rst)
    ndig <= CNT_W'(VALUE_BITS))
    else $error("digit count past value width");

  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_base) |-> (last && digit_char == '0))
    else $error("bad-base beat malformed");

  a_div_base: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (base_r >= MIN_BASE && base_r <= MAX_BASE))
    else $error("divide running on invalid base");

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (BASE_W'(rem) < base_r))
    else $error("partial remainder not below base");

endmodule

### sv/unsigned_to_ascii_any_base.sv
// Timing: a bad base shows its single beat once the engine is idle and the
// output register is free; a valid conversion of D digits runs bit-serial
// division per digit after a start state, then reads each digit beat through
// the ST_RD and ST_WR states while pop keeps up.
// Flow: one conversion at a time in the divider; the queue takes beats meanwhile.
// Reset: rst (sync, active high) clears queue and engine control; the digit
// RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// unsigned_to_ascii_any_base
// Converts an unsigned value to lower-case ASCII digits in base 2 to 36,
// most significant digit first.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_any_base (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [uaa_pkg::IN_W-1:0]    value,
  input  logic [uaa_pkg::BASE_W-1:0]  base,
  output logic                        empty,
  input  logic                        pop,
  output logic [uaa_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last,
  output logic                        bad_base
);

  import uaa_pkg::*;

  job_t job;
  logic job_valid;
  logic job_pop;

  uaa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .value     (value),
    .base      (base),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop)
  );

  uaa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job        (job),
    .job_valid  (job_valid),
    .job_pop    (job_pop),
    .empty      (empty),
    .pop        (pop),
    .digit_char (digit_char),
    .last       (last),
    .bad_base   (bad_base)
  );

endmodule

### test/uaa_checker.sv
// ----------------------------------------------------------------------------
// uaa_checker
// Watches both queue ports of the radix converter. Every accepted value/base
// beat is converted here to its expected digit beats, most significant first;
// every popped beat is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module uaa_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  logic [uaa_pkg::IN_W-1:0]    value,
  input  logic [uaa_pkg::BASE_W-1:0]  base,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [uaa_pkg::CHAR_W-1:0]  digit_char,
  input  logic                        last,
  input  logic                        bad_base,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import uaa_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              bad;
  } digit_beat_t;

  digit_beat_t digits_due[$];

  // Expected beats of one conversion, appended to the queue.
  task automatic convert_to_digits(input logic [IN_W-1:0] v_in,
                                   input logic [BASE_W-1:0] b);
    logic [DIGIT_W-1:0] rem_lsf[VALUE_BITS];
    logic [VALUE_BITS-1:0] quot;
    int n;
    digit_beat_t bt;
    if (b < MIN_BASE || b > MAX_BASE) begin
      bt = '{ch: '0, last: 1'b1, bad: 1'b1};
      digits_due.push_back(bt);
      return;
    end
    quot = v_in[VALUE_BITS-1:0];
    n = 0;
    do begin
      rem_lsf[n] = DIGIT_W'(quot % b);
      quot = quot / b;
      n++;
    end while (quot != 0 && n < VALUE_BITS);
    for (int k = n - 1; k >= 0; k--) begin
      if (rem_lsf[k] < 10) bt.ch = CHAR_W'(8'h30 + rem_lsf[k]);       // '0'..'9'
      else bt.ch = CHAR_W'(8'h61 + rem_lsf[k] - 10);                  // 'a'..'z'
      bt.last = (k == 0);
      bt.bad  = 1'b0;
      digits_due.push_back(bt);
    end
  endtask

  always @(posedge clk) begin
    digit_beat_t want;
    if (rst) begin
      digits_due.delete();
    end else begin
      // result side first: a beat never leaves in the cycle its input arrives
      if (pop && !empty) begin
        if (digits_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat char=%h last=%b bad_base=%b",
                   $realtime, digit_char, last, bad_base);
        end else begin
          want = digits_due.pop_front();
          if (digit_char !== want.ch) begin
            errors++;
            $display("%0t: digit_char expected %h actual %h", $realtime, want.ch, digit_char);
          end
          if (last !== want.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $realtime, want.last, last);
          end
          if (bad_base !== want.bad) begin
            errors++;
            $display("%0t: bad_base expected %b actual %b", $realtime, want.bad, bad_base);
          end
        end
      end
      if (push && !full) convert_to_digits(value, base);
    end
    pending = digits_due.size();
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the radix converter: directed corner values and bases, then
// random beats under three idle patterns. Checking lives in uaa_checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uaa_pkg::*;

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  logic [IN_W-1:0]     value;
  logic [BASE_W-1:0]   base;
  logic                empty;
  logic                pop;
  logic [CHAR_W-1:0]   digit_char;
  logic                last;
  logic                bad_base;
  int                  errors;
  int                  pending;
  int                  tx_idle_pct;
  int                  rx_idle_pct;

  unsigned_to_ascii_any_base i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .value      (value),
    .base       (base),
    .empty      (empty),
    .pop        (pop),
    .digit_char (digit_char),
    .last       (last),
    .bad_base   (bad_base)
  );

  uaa_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .value      (value),
    .base       (base),
    .empty      (empty),
    .pop        (pop),
    .digit_char (digit_char),
    .last       (last),
    .bad_base   (bad_base),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[unsigned_to_ascii_any_base] ERROR");
    $finish;
  end

  // receiver: random pop stalls
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_beat(input logic [IN_W-1:0] v, input logic [BASE_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push  <= 1'b1;
    value <= v;
    base  <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 40);
      2: return (32'h1 << $urandom_range(31)) - $urandom_range(1);
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  function automatic logic [BASE_W-1:0] pick_base();
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(3) == 0) return BASE_W'($urandom_range(1));
      return BASE_W'($urandom_range(37, 63));
    end
    return BASE_W'($urandom_range(2, 36));
  endfunction

  task automatic random_run(input int count);
    for (int i = 0; i < count; i++) send_beat(pick_value(), pick_base());
  endtask

  initial begin
    rst         = 1'b1;
    push        = 1'b0;
    value       = '0;
    base        = '0;
    tx_idle_pct = 8;
    rx_idle_pct = 55;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero value, widest and narrowest digit strings, single digits
    send_beat(32'h0, 6'd10);
    send_beat(32'h0, 6'd2);
    send_beat(32'h0, 6'd36);
    send_beat(32'hFFFF_FFFF, 6'd2);
    send_beat(32'hFFFF_FFFF, 6'd36);
    send_beat(32'hFFFF_FFFF, 6'd10);
    send_beat(32'hFFFF_FFFF, 6'd16);
    send_beat(32'h8000_0000, 6'd2);
    send_beat(32'h1, 6'd2);
    send_beat(32'd35, 6'd36);
    send_beat(32'd36, 6'd36);
    send_beat(32'd9, 6'd10);
    send_beat(32'd10, 6'd11);
    send_beat(32'd1234567890, 6'd35);
    send_beat(32'hDEAD_BEEF, 6'd3);
    // bad bases, including the bounds just outside the range
    send_beat(32'h0, 6'd0);
    send_beat(32'h5A5A_A5A5, 6'd1);
    send_beat(32'hFFFF_FFFF, 6'd37);
    send_beat(32'h1234_5678, 6'd63);
    send_beat(32'h0, 6'd37);

    random_run(15);
    // hold off until the converter has emptied completely
    push <= 1'b0;
    drain_results();
    @(posedge clk);
    random_run(15);

    tx_idle_pct = 55;
    rx_idle_pct = 8;
    random_run(30);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_run(30);

    push <= 1'b0;
    drain_results();
    repeat (40) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("[unsigned_to_ascii_any_base] OK");
    end else begin
      $display("[unsigned_to_ascii_any_base] ERROR");
    end
    $finish;
  end

endmodule
